### rtl/spi24_pkg.sv
package spi24_pkg;

    localparam int ADDR_BITS   = 8;
    localparam int DATA_BITS   = 16;
    localparam int FRAME_BITS  = ADDR_BITS + DATA_BITS;
    localparam int REG_ADDR_W  = ADDR_BITS - 1;
    localparam int TICKS_W     = 16;
    localparam int BIT_IDX_W   = 5;
    localparam int STEP_W      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_CHIP_ENABLE = 1'b1;

    localparam logic [TICKS_W-1:0] PHASE_TICKS_RESET = 16'd4;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [REG_ADDR_W-1:0] reg_address;
        logic [DATA_BITS-1:0]  write_data;
        logic                  readback_in;
    } spi24_req_t;

    typedef enum logic [2:0] {
        FRAME_IDLE  = 3'b001,
        FRAME_WRITE = 3'b010,
        FRAME_READ  = 3'b100
    } frame_kind_t;

endpackage

### rtl/spi24_front.sv
module spi24_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       mode,
    input  logic [spi24_pkg::REG_ADDR_W-1:0] reg_address,
    input  logic [spi24_pkg::DATA_BITS-1:0]  write_data,
    input  logic                             readback_in,
    output logic                             req_valid,
    input  logic                             req_ready,
    output spi24_pkg::spi24_req_t            req
);
    import spi24_pkg::*;

    spi24_req_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg;
    logic [QCNT_W-1:0]       count_next;
    logic                    push;
    logic                    pop;
    spi24_req_t              classified;

    // Classify: anything that is not a start counts as a tick
    always_comb
    begin
        classified.reg_address = reg_address;
        classified.write_data  = write_data;
        classified.readback_in = readback_in;
        unique case (mode)
            MODE_WRITE: classified.kind = CMD_WRITE;
            MODE_READ:  classified.kind = CMD_READ;
            default:    classified.kind = CMD_TICK;
        endcase
    end

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = in_valid && in_ready;
    assign req_valid = (count_reg != '0);
    assign pop       = req_valid && req_ready;
    assign req       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("request queue count overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(1)) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

### rtl/spi24_back.sv
module spi24_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  spi24_pkg::spi24_req_t            req,
    input  logic [spi24_pkg::TICKS_W-1:0]    phase_ticks,
    input  logic                             chip_enable,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             csb_pin,
    output logic                             sclk_pin,
    output logic                             sdi_pin,
    output logic                             ce_pin,
    output logic                             busy_res,
    output logic                             done_res,
    output logic [spi24_pkg::DATA_BITS-1:0]  read_data,
    output logic                             rejected
);
    import spi24_pkg::*;

    frame_kind_t             kind_reg;
    frame_kind_t             kind_next;
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic [BIT_IDX_W-1:0]    bit_reg;
    logic [BIT_IDX_W-1:0]    bit_next;
    logic [TICKS_W-1:0]      hold_reg;
    logic [TICKS_W-1:0]      hold_next;
    logic [FRAME_BITS-1:0]   shift_out_reg;
    logic [FRAME_BITS-1:0]   shift_out_next;
    logic [DATA_BITS-1:0]    shift_in_reg;
    logic [DATA_BITS-1:0]    shift_in_next;
    logic                    csb_reg;
    logic                    csb_next;
    logic                    sclk_reg;
    logic                    sclk_next;
    logic                    sdi_reg;
    logic                    sdi_next;
    logic                    out_valid_reg;
    logic                    ce_out_reg;
    logic                    busy_out_reg;
    logic                    done_out_reg;
    logic                    rej_out_reg;
    logic                    done_next;
    logic                    rej_next;
    logic                    enter;
    logic                    fire;
    logic                    busy;

    assign req_ready = !out_valid_reg || out_ready;
    assign fire      = req_valid && req_ready;
    assign busy      = (kind_reg != FRAME_IDLE);

    always_comb
    begin
        kind_next      = kind_reg;
        step_next      = step_reg;
        bit_next       = bit_reg;
        hold_next      = hold_reg;
        shift_out_next = shift_out_reg;
        shift_in_next  = shift_in_reg;
        csb_next       = csb_reg;
        sclk_next      = sclk_reg;
        sdi_next       = sdi_reg;
        done_next      = 1'b0;
        rej_next       = 1'b0;
        enter          = 1'b0;

        if (req.kind == CMD_WRITE || req.kind == CMD_READ)
        begin
            if (busy)
            begin
                rej_next = 1'b1;
            end
            else if (req.kind == CMD_WRITE)
            begin
                kind_next      = FRAME_WRITE;
                shift_out_next = {1'b0, req.reg_address, req.write_data};
                bit_next       = '0;
                step_next      = '0;
                enter          = 1'b1;
            end
            else
            begin
                kind_next      = FRAME_READ;
                shift_out_next = {1'b1, req.reg_address, DATA_BITS'(0)};
                shift_in_next  = '0;
                bit_next       = BIT_IDX_W'(1);
                step_next      = '0;
                enter          = 1'b1;
            end
        end
        else if (busy)
        begin
            if (hold_reg > TICKS_W'(1))
            begin
                hold_next = hold_reg - TICKS_W'(1);
            end
            else
            begin
                // Advance to the next phase, or close the frame
                enter = 1'b1;
                unique case (kind_reg)
                    FRAME_WRITE:
                    begin
                        if (bit_reg == '0)
                        begin
                            if (step_reg == '0)
                            begin
                                step_next = STEP_W'(1);
                            end
                            else
                            begin
                                bit_next  = BIT_IDX_W'(1);
                                step_next = '0;
                            end
                        end
                        else if (bit_reg <= BIT_IDX_W'(FRAME_BITS))
                        begin
                            if (step_reg < STEP_W'(2))
                            begin
                                step_next = step_reg + STEP_W'(1);
                            end
                            else
                            begin
                                bit_next  = bit_reg + BIT_IDX_W'(1);
                                step_next = '0;
                            end
                        end
                        else
                        begin
                            enter = 1'b0;
                        end
                    end
                    FRAME_READ:
                    begin
                        if (bit_reg <= BIT_IDX_W'(ADDR_BITS))
                        begin
                            if (step_reg < STEP_W'(2))
                            begin
                                step_next = step_reg + STEP_W'(1);
                            end
                            else
                            begin
                                bit_next  = bit_reg + BIT_IDX_W'(1);
                                step_next = '0;
                            end
                        end
                        else if (step_reg == '0)
                        begin
                            step_next = STEP_W'(1);
                        end
                        else if (bit_reg < BIT_IDX_W'(FRAME_BITS))
                        begin
                            bit_next  = bit_reg + BIT_IDX_W'(1);
                            step_next = '0;
                        end
                        else
                        begin
                            enter = 1'b0;
                        end
                    end
                    default:
                    begin
                        enter = 1'b0;
                    end
                endcase

                if (!enter)
                begin
                    // Frame complete: a read releases csb here
                    if (kind_reg == FRAME_READ)
                    begin
                        csb_next = 1'b1;
                    end
                    kind_next = FRAME_IDLE;
                    step_next = '0;
                    bit_next  = '0;
                    hold_next = '0;
                    done_next = 1'b1;
                end
            end
        end

        // Apply the pin change of the phase just entered and restart its hold
        if (enter)
        begin
            if (kind_next == FRAME_WRITE)
            begin
                if (bit_next == '0)
                begin
                    if (step_next == '0)
                    begin
                        sclk_next = 1'b0;
                    end
                    else
                    begin
                        sdi_next = 1'b0;
                        csb_next = 1'b0;
                    end
                end
                else if (bit_next <= BIT_IDX_W'(FRAME_BITS))
                begin
                    if (step_next == '0)
                    begin
                        sdi_next       = shift_out_next[FRAME_BITS-1];
                        shift_out_next = {shift_out_next[FRAME_BITS-2:0], 1'b0};
                    end
                    else if (step_next == STEP_W'(1))
                    begin
                        sclk_next = 1'b1;
                    end
                    else
                    begin
                        sclk_next = 1'b0;
                    end
                end
                else
                begin
                    csb_next = 1'b1;
                end
            end
            else
            begin
                if (bit_next <= BIT_IDX_W'(ADDR_BITS))
                begin
                    if (step_next == '0)
                    begin
                        sclk_next = 1'b0;
                        if (bit_next == BIT_IDX_W'(1))
                        begin
                            csb_next = 1'b0;
                        end
                    end
                    else if (step_next == STEP_W'(1))
                    begin
                        sdi_next       = shift_out_next[FRAME_BITS-1];
                        shift_out_next = {shift_out_next[FRAME_BITS-2:0], 1'b0};
                    end
                    else
                    begin
                        sclk_next = 1'b1;
                    end
                end
                else
                begin
                    if (step_next == '0)
                    begin
                        sclk_next = 1'b0;
                    end
                    else
                    begin
                        shift_in_next = {shift_in_next[DATA_BITS-2:0], req.readback_in};
                        sclk_next     = 1'b1;
                    end
                end
            end
            hold_next = (phase_ticks != '0) ? phase_ticks : TICKS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= FRAME_IDLE;
            step_reg      <= '0;
            bit_reg       <= '0;
            hold_reg      <= '0;
            shift_out_reg <= '0;
            shift_in_reg  <= '0;
            csb_reg       <= 1'b1;
            sclk_reg      <= 1'b0;
            sdi_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                kind_reg      <= kind_next;
                step_reg      <= step_next;
                bit_reg       <= bit_next;
                hold_reg      <= hold_next;
                shift_out_reg <= shift_out_next;
                shift_in_reg  <= shift_in_next;
                csb_reg       <= csb_next;
                sclk_reg      <= sclk_next;
                sdi_reg       <= sdi_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result flags; pins and read data come straight from the sequencer state
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ce_out_reg   <= chip_enable;
            busy_out_reg <= (kind_next != FRAME_IDLE);
            done_out_reg <= done_next;
            rej_out_reg  <= rej_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign csb_pin   = csb_reg;
    assign sclk_pin  = sclk_reg;
    assign sdi_pin   = sdi_reg;
    assign ce_pin    = ce_out_reg;
    assign busy_res  = busy_out_reg;
    assign done_res  = done_out_reg;
    assign read_data = shift_in_reg;
    assign rejected  = rej_out_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_out_reg) |-> (!busy_out_reg && csb_reg))
        else $error("frame done but still busy or csb low");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rej_out_reg) |-> (busy_out_reg && !done_out_reg))
        else $error("request rejected while idle");

    a_hold_live: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg != FRAME_IDLE) |-> (hold_reg != '0))
        else $error("phase hold empty during a frame");

    a_idle_csb: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg == FRAME_IDLE) |-> csb_reg)
        else $error("csb low with no frame in progress");

endmodule

### rtl/spi_24bit_register_master.sv
// A request accepted from the input passes through the request queue and then the pin
// sequencer's output register before its result appears. Throughput: one request per cycle
// unless the output stalls; each request moves the sequencer by at most one phase.
// A two-entry queue decouples input acceptance from the sequencer and the output stall.
// Reset: csb high, sclk/sdi low, chip enable 0, no frame, queue and result empty,
// phase_ticks 4.
module spi_24bit_register_master (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [spi24_pkg::TICKS_W-1:0]    cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       mode,
    input  logic [spi24_pkg::REG_ADDR_W-1:0] reg_address,
    input  logic [spi24_pkg::DATA_BITS-1:0]  write_data,
    input  logic                             readback_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             csb_pin,
    output logic                             sclk_pin,
    output logic                             sdi_pin,
    output logic                             ce_pin,
    output logic                             busy_res,
    output logic                             done_res,
    output logic [spi24_pkg::DATA_BITS-1:0]  read_data,
    output logic                             rejected
);
    import spi24_pkg::*;

    logic [TICKS_W-1:0] phase_ticks_reg;
    logic               chip_enable_reg;
    logic               req_valid;
    logic               req_ready;
    spi24_req_t         req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            chip_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PHASE_TICKS: phase_ticks_reg <= cfg_data;
                CFG_CHIP_ENABLE: chip_enable_reg <= cfg_data[0];
                default:         phase_ticks_reg <= phase_ticks_reg;
            endcase
        end
    end

    spi24_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .reg_address (reg_address),
        .write_data  (write_data),
        .readback_in (readback_in),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req)
    );

    spi24_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .phase_ticks (phase_ticks_reg),
        .chip_enable (chip_enable_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .csb_pin     (csb_pin),
        .sclk_pin    (sclk_pin),
        .sdi_pin     (sdi_pin),
        .ce_pin      (ce_pin),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .read_data   (read_data),
        .rejected    (rejected)
    );

endmodule

### dv/spi_24bit_register_master_tb.sv
`timescale 1ns / 100ps

module spi_24bit_register_master_tb;

    import spi24_pkg::*;

    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam int         RUN_ITEMS    = 1200;
    localparam int         QUIET_ITEMS  = 300;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         SETTLE_EDGES = 8;

    typedef struct {
        logic                 csb;
        logic                 sclk;
        logic                 sdi;
        logic                 ce;
        logic                 busy;
        logic                 done;
        logic [DATA_BITS-1:0] rdata;
        logic                 rej;
    } pin_state_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [TICKS_W-1:0]    cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            mode;
    logic [REG_ADDR_W-1:0] reg_address;
    logic [DATA_BITS-1:0]  write_data;
    logic                  readback_in;
    logic                  out_valid;
    logic                  out_ready;
    logic                  csb_pin;
    logic                  sclk_pin;
    logic                  sdi_pin;
    logic                  ce_pin;
    logic                  busy_res;
    logic                  done_res;
    logic [DATA_BITS-1:0]  read_data;
    logic                  rejected;

    pin_state_t pending_pins[$];
    int         errors          = 0;
    int         sent_count      = 0;
    int         cycles          = 0;
    int         hold_off_cycles = 0;
    bit         in_idle_en      = 1'b1;
    bit         out_idle_en     = 1'b1;

    // Sequencer shadow state
    logic [TICKS_W-1:0]    m_ticks = PHASE_TICKS_RESET;
    logic                  m_ce    = 1'b0;
    frame_kind_t           m_kind  = FRAME_IDLE;
    logic [STEP_W-1:0]     m_step  = '0;
    logic [BIT_IDX_W-1:0]  m_bit   = '0;
    int unsigned           m_hold  = 0;
    logic [FRAME_BITS-1:0] m_sout  = '0;
    logic [DATA_BITS-1:0]  m_sin   = '0;
    logic                  m_csb   = 1'b1;
    logic                  m_sclk  = 1'b0;
    logic                  m_sdi   = 1'b0;

    spi_24bit_register_master i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic take_frame_bit();
        logic b;
        b      = m_sout[FRAME_BITS-1];
        m_sout = m_sout << 1;
        return b;
    endfunction

    // Drive the pins of the phase just entered and restart its hold.
    function automatic void load_phase(logic rb);
        if (m_kind == FRAME_WRITE)
        begin
            if (m_bit == 0)
            begin
                if (m_step == 0)
                    m_sclk = 1'b0;
                else
                begin
                    m_sdi = 1'b0;
                    m_csb = 1'b0;
                end
            end
            else if (m_bit <= FRAME_BITS)
            begin
                if (m_step == 0)
                    m_sdi = take_frame_bit();
                else if (m_step == 1)
                    m_sclk = 1'b1;
                else
                    m_sclk = 1'b0;
            end
            else
                m_csb = 1'b1;
        end
        else
        begin
            if (m_bit <= ADDR_BITS)
            begin
                if (m_step == 0)
                begin
                    m_sclk = 1'b0;
                    if (m_bit == 1)
                        m_csb = 1'b0;
                end
                else if (m_step == 1)
                    m_sdi = take_frame_bit();
                else
                    m_sclk = 1'b1;
            end
            else if (m_step == 0)
                m_sclk = 1'b0;
            else
            begin
                m_sin  = {m_sin[DATA_BITS-2:0], rb};
                m_sclk = 1'b1;
            end
        end
        m_hold = (m_ticks != 0) ? m_ticks : 1;
    endfunction

    // Advance one phase; returns 1 when the frame completes.
    function automatic logic next_phase(logic rb);
        logic last;
        last = 1'b0;
        if (m_kind == FRAME_WRITE)
        begin
            if (m_bit == 0)
            begin
                if (m_step == 0)
                    m_step = 2'd1;
                else
                begin
                    m_bit  = 5'd1;
                    m_step = '0;
                end
            end
            else if (m_bit <= FRAME_BITS)
            begin
                if (m_step < 2)
                    m_step = m_step + 2'd1;
                else
                begin
                    m_bit  = m_bit + 5'd1;
                    m_step = '0;
                end
            end
            else
                last = 1'b1;
        end
        else
        begin
            if (m_bit <= ADDR_BITS)
            begin
                if (m_step < 2)
                    m_step = m_step + 2'd1;
                else
                begin
                    m_bit  = m_bit + 5'd1;
                    m_step = '0;
                end
            end
            else if (m_step == 0)
                m_step = 2'd1;
            else if (m_bit < FRAME_BITS)
            begin
                m_bit  = m_bit + 5'd1;
                m_step = '0;
            end
            else
                last = 1'b1;
        end
        if (last)
        begin
            if (m_kind == FRAME_READ)
                m_csb = 1'b1;
            m_kind = FRAME_IDLE;
            m_step = '0;
            m_bit  = '0;
            m_hold = 0;
        end
        else
            load_phase(rb);
        return last;
    endfunction

    function automatic pin_state_t predict_pins(logic [1:0] md, logic [REG_ADDR_W-1:0] addr,
                                                logic [DATA_BITS-1:0] data, logic rb);
        pin_state_t res;
        logic       busy;
        busy     = (m_kind != FRAME_IDLE);
        res.done = 1'b0;
        res.rej  = 1'b0;
        if (md == MODE_WRITE || md == MODE_READ)
        begin
            if (busy)
                res.rej = 1'b1;
            else if (md == MODE_WRITE)
            begin
                m_kind = FRAME_WRITE;
                m_sout = {1'b0, addr, data};
                m_bit  = '0;
                m_step = '0;
                load_phase(rb);
            end
            else
            begin
                m_kind = FRAME_READ;
                m_sout = {1'b1, addr, {DATA_BITS{1'b0}}};
                m_sin  = '0;
                m_bit  = 5'd1;
                m_step = '0;
                load_phase(rb);
            end
        end
        else if (busy)
        begin
            if (m_hold > 1)
                m_hold--;
            else
                res.done = next_phase(rb);
        end
        res.csb   = m_csb;
        res.sclk  = m_sclk;
        res.sdi   = m_sdi;
        res.ce    = m_ce;
        res.busy  = (m_kind != FRAME_IDLE);
        res.rdata = m_sin;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h (cycle %0d)", field, got, want, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        pin_state_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pins.size() == 0)
                report_mismatch("result with no request pending", 0, 0);
            else
            begin
                want = pending_pins.pop_front();
                if (csb_pin !== want.csb)
                    report_mismatch("csb_pin", 32'(csb_pin), 32'(want.csb));
                if (sclk_pin !== want.sclk)
                    report_mismatch("sclk_pin", 32'(sclk_pin), 32'(want.sclk));
                if (sdi_pin !== want.sdi)
                    report_mismatch("sdi_pin", 32'(sdi_pin), 32'(want.sdi));
                if (ce_pin !== want.ce)
                    report_mismatch("ce_pin", 32'(ce_pin), 32'(want.ce));
                if (busy_res !== want.busy)
                    report_mismatch("busy_res", 32'(busy_res), 32'(want.busy));
                if (done_res !== want.done)
                    report_mismatch("done_res", 32'(done_res), 32'(want.done));
                if (read_data !== want.rdata)
                    report_mismatch("read_data", 32'(read_data), 32'(want.rdata));
                if (rejected !== want.rej)
                    report_mismatch("rejected", 32'(rejected), 32'(want.rej));
            end
        end
    end

    // Result side: long hold-off first, then random stall bursts.
    initial
    begin
        int gap;
        gap       = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (gap > 0)
            begin
                out_ready <= 1'b0;
                gap--;
            end
            else if (out_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                gap = $urandom_range(0, 11);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_req(input logic [1:0] md, input logic [REG_ADDR_W-1:0] addr,
                            input logic [DATA_BITS-1:0] data, input logic rb);
        int gap;
        if (in_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        in_valid    <= 1'b1;
        mode        <= md;
        reg_address <= addr;
        write_data  <= data;
        readback_in <= rb;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pins.push_back(predict_pins(md, addr, data, rb));
        sent_count++;
    endtask

    task automatic send_tick();
        send_req(($urandom_range(0, 7) == 0) ? MODE_SPARE : MODE_TICK,
                 REG_ADDR_W'($urandom_range(0, 127)), DATA_BITS'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)));
    endtask

    task automatic send_start();
        send_req($urandom_range(0, 1) ? MODE_READ : MODE_WRITE,
                 REG_ADDR_W'($urandom_range(0, 127)), DATA_BITS'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)));
    endtask

    // Stop offering requests and wait for every pin result to come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [TICKS_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PHASE_TICKS)
            m_ticks = value;
        else
            m_ce = value[0];
    endtask

    task automatic finish_frame(input int noise_pct, input int cfg_pct);
        int r;
        while (m_kind != FRAME_IDLE)
        begin
            r = $urandom_range(0, 99);
            if (r < noise_pct)
                send_start();
            else if (r < noise_pct + cfg_pct)
                cfg_write($urandom_range(0, 1) ? CFG_CHIP_ENABLE : CFG_PHASE_TICKS,
                          TICKS_W'($urandom_range(0, 3)));
            else
                send_tick();
        end
    endtask

    task automatic test_idle_ticks();
        send_req(MODE_TICK, '0, '0, 1'b0);
        send_req(MODE_SPARE, '1, '1, 1'b1);
    endtask

    task automatic test_write_frame();
        cfg_write(CFG_PHASE_TICKS, '0);
        cfg_write(CFG_CHIP_ENABLE, 16'd1);
        send_req(MODE_WRITE, '1, '1, 1'b0);
        send_req(MODE_READ, '0, '0, 1'b1);
        send_req(MODE_WRITE, '0, '0, 1'b0);
        while (!(m_kind == FRAME_WRITE && m_bit > FRAME_BITS))
            send_tick();
        // hold of the closing phase is already loaded, so the maximum never counts down
        cfg_write(CFG_PHASE_TICKS, '1);
        finish_frame(0, 0);
        cfg_write(CFG_PHASE_TICKS, 16'd1);
        send_req(MODE_WRITE, '0, '0, 1'b1);
        finish_frame(0, 0);
    endtask

    task automatic test_read_frame();
        cfg_write(CFG_PHASE_TICKS, 16'd3);
        send_req(MODE_READ, '0, '1, 1'b1);
        while (m_bit <= ADDR_BITS)
            send_tick();
        cfg_write(CFG_PHASE_TICKS, 16'd1);
        cfg_write(CFG_CHIP_ENABLE, 16'd0);
        send_req(MODE_WRITE, '1, '1, 1'b1);
        finish_frame(0, 0);
        send_req(MODE_READ, '1, '0, 1'b0);
        finish_frame(0, 0);
    endtask

    task automatic test_backpressure();
        drain_results();
        in_idle_en      = 1'b0;
        out_idle_en     = 1'b0;
        hold_off_cycles = 80;
        send_start();
        repeat (30) send_tick();
        finish_frame(0, 0);
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_start();
        repeat (10) send_tick();
        drain_results();
        finish_frame(0, 0);
    endtask

    task automatic test_random();
        int first;
        int r;
        first = sent_count;
        while (sent_count - first < RUN_ITEMS)
        begin
            if (sent_count - first > RUN_ITEMS - QUIET_ITEMS)
            begin
                in_idle_en  = 1'b0;
                out_idle_en = 1'b0;
            end
            else
            begin
                in_idle_en  = ($urandom_range(0, 3) != 0);
                out_idle_en = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    cfg_write(CFG_PHASE_TICKS, TICKS_W'($urandom_range(0, 1)));
                else if (r < 8)
                    cfg_write(CFG_PHASE_TICKS, TICKS_W'($urandom_range(2, 4)));
                else
                    cfg_write(CFG_PHASE_TICKS, TICKS_W'($urandom_range(5, 12)));
                cfg_write(CFG_CHIP_ENABLE, TICKS_W'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4)) send_tick();
            send_start();
            finish_frame(4, 2);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_PHASE_TICKS;
        cfg_data    = '0;
        in_valid    = 1'b0;
        mode        = MODE_TICK;
        reg_address = '0;
        write_data  = '0;
        readback_in = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_ticks();
        test_write_frame();
        test_read_frame();
        test_backpressure();
        test_sender_pause();
        test_random();

        drain_results();
        repeat (SETTLE_EDGES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
